// ===== hdl/u2bd_pkg.sv =====
package u2bd_pkg;

    // Default parameter values for the top level
    localparam int MAX_SYMBOLS_DEF = 16;
    localparam int VALUE_BITS_DEF  = 64;
    localparam int MAX_DIGITS_DEF  = 64;

    // Fixed field and register widths
    localparam int VALUE_W    = 64;
    localparam int CHAR_W     = 8;
    localparam int DIGIT_W    = 4;
    localparam int RADIX_W    = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 64;
    localparam int SYMBOL_NUM = 16;

    // Dividend bits retired per divider cycle
    localparam int STEP_BITS = 8;

    // Entries in the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SYMBOL_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SYMBOLS_LOW  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SYMBOLS_HIGH = 2'd2;

    // Character codes
    localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;

    localparam int SYMBOL_COUNT_RESET = 10;

    // Class of a queued job
    typedef enum logic [1:0] {
        KIND_INVALID,
        KIND_ZERO,
        KIND_NUMBER
    } kind_t;

    typedef struct packed {
        kind_t              kind;
        logic [VALUE_W-1:0] value;
    } job_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIVIDE,
        BK_EMIT
    } back_state_t;

    // Pick symbol idx out of the two packed symbol registers
    function automatic logic [CHAR_W-1:0] symbol_at(
        input logic [CFG_DATA_W-1:0] lo,
        input logic [CFG_DATA_W-1:0] hi,
        input logic [DIGIT_W-1:0]    idx
    );
        logic [CFG_DATA_W-1:0] word;
        word = idx[3] ? hi : lo;
        return word[idx[2:0]*CHAR_W +: CHAR_W];
    endfunction

endpackage

// ===== hdl/u2bd_ram.sv =====
module u2bd_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write one entry, read one entry with registered data
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hdl/u2bd_front.sv =====
module u2bd_front #(
    parameter int MAX_SYMBOLS = u2bd_pkg::MAX_SYMBOLS_DEF,
    parameter int VALUE_BITS  = u2bd_pkg::VALUE_BITS_DEF
) (
    input  logic                             start,
    output logic                             busy,
    input  logic [u2bd_pkg::VALUE_W-1:0]     value,
    input  logic [u2bd_pkg::RADIX_W-1:0]     symbol_count,
    input  logic [u2bd_pkg::CFG_DATA_W-1:0]  symbols_low,
    input  logic [u2bd_pkg::CFG_DATA_W-1:0]  symbols_high,
    input  logic                             queue_full,
    output logic                             push,
    output u2bd_pkg::job_t                   job
);

    logic base_bad;

    // Check the symbol set: count range, sign characters, duplicates
    always_comb
    begin
        logic [MAX_SYMBOLS-1:0]       in_use;
        logic [u2bd_pkg::CHAR_W-1:0]  sym [MAX_SYMBOLS];
        logic                         bad;
        for (int i = 0; i < MAX_SYMBOLS; i++)
        begin
            in_use[i] = (u2bd_pkg::RADIX_W'(i) < symbol_count);
            sym[i]    = u2bd_pkg::symbol_at(symbols_low, symbols_high,
                                            u2bd_pkg::DIGIT_W'(i));
        end
        bad = (symbol_count < u2bd_pkg::RADIX_W'(2)) ||
              (symbol_count > u2bd_pkg::RADIX_W'(MAX_SYMBOLS));
        for (int i = 0; i < MAX_SYMBOLS; i++)
        begin
            if (in_use[i] && (sym[i] == u2bd_pkg::CHAR_PLUS ||
                              sym[i] == u2bd_pkg::CHAR_MINUS))
            begin
                bad = 1'b1;
            end
            for (int j = i + 1; j < MAX_SYMBOLS; j++)
            begin
                if (in_use[j] && sym[j] == sym[i])
                begin
                    bad = 1'b1;
                end
            end
        end
        base_bad = bad;
    end

    // Accept a transaction whenever the queue has room, and classify it
    assign busy = queue_full;
    assign push = start && !queue_full;

    always_comb
    begin
        job.value = '0;
        job.value[VALUE_BITS-1:0] = value[VALUE_BITS-1:0];
        priority if (base_bad)
        begin
            job.kind = u2bd_pkg::KIND_INVALID;
        end
        else if (value[VALUE_BITS-1:0] == '0)
        begin
            job.kind = u2bd_pkg::KIND_ZERO;
        end
        else
        begin
            job.kind = u2bd_pkg::KIND_NUMBER;
        end
    end

endmodule

// ===== hdl/u2bd_queue.sv =====
module u2bd_queue #(
    parameter int DEPTH = u2bd_pkg::QUEUE_DEPTH
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  u2bd_pkg::job_t push_job,
    input  logic           pop,
    output logic           full,
    output logic           not_empty,
    output u2bd_pkg::job_t head
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    u2bd_pkg::job_t slots_reg [DEPTH];
    logic [PW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]  count_reg, count_next;

    assign full      = (count_reg == CW'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = slots_reg[rd_ptr_reg];

    // Advance pointers with wrap and track the fill level
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Hold job payloads
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

// ===== hdl/u2bd_back.sv =====
module u2bd_back #(
    parameter int VALUE_BITS = u2bd_pkg::VALUE_BITS_DEF,
    parameter int MAX_DIGITS = u2bd_pkg::MAX_DIGITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             job_valid,
    input  u2bd_pkg::job_t                   job,
    output logic                             pop,
    input  logic [u2bd_pkg::RADIX_W-1:0]     radix,
    input  logic [u2bd_pkg::CFG_DATA_W-1:0]  symbols_low,
    input  logic [u2bd_pkg::CFG_DATA_W-1:0]  symbols_high,
    output logic                             result_valid,
    output logic [u2bd_pkg::CHAR_W-1:0]      digit_char,
    output logic                             last_digit,
    output logic                             base_invalid
);

    localparam int SB     = u2bd_pkg::STEP_BITS;
    localparam int DW     = u2bd_pkg::DIGIT_W;
    localparam int STEPS  = (VALUE_BITS + SB - 1) / SB;
    localparam int DIV_W  = STEPS * SB;
    localparam int STEP_W = (STEPS > 1) ? $clog2(STEPS) : 1;
    localparam int AW     = $clog2(MAX_DIGITS);

    u2bd_pkg::back_state_t state_reg, state_next;

    logic [DIV_W-1:0]  div_reg, div_next;
    logic [DW-1:0]     part_reg, part_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [AW-1:0]     idx_reg, idx_next;
    logic [AW-1:0]     rd_addr_reg, rd_addr_next;
    logic              rd_pending_reg, rd_pending_next;
    logic              rd_last_reg, rd_last_next;

    logic                        result_valid_reg, result_valid_next;
    logic [u2bd_pkg::CHAR_W-1:0] digit_char_reg, digit_char_next;
    logic                        last_digit_reg, last_digit_next;
    logic                        base_invalid_reg, base_invalid_next;

    logic [DIV_W-1:0] step_quo;
    logic [DW-1:0]    step_rem;
    logic             ram_we;
    logic [DW-1:0]    ram_rdata;

    // Divide: retire eight dividend bits per cycle, restoring style
    always_comb
    begin
        logic [DW:0]    trial;
        logic [DW-1:0]  rem;
        logic [SB-1:0]  chunk;
        logic [SB-1:0]  qbits;
        chunk = div_reg[DIV_W-1 -: SB];
        rem   = part_reg;
        qbits = '0;
        for (int b = SB - 1; b >= 0; b--)
        begin
            trial = {rem, chunk[b]};
            if (trial >= radix)
            begin
                trial    = trial - radix;
                qbits[b] = 1'b1;
            end
            rem = trial[DW-1:0];
        end
        step_rem = rem;
        step_quo = DIV_W'({div_reg, qbits});
    end

    // Digit store, least significant digit first
    u2bd_ram #(
        .WIDTH (DW),
        .DEPTH (MAX_DIGITS)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (idx_reg),
        .wdata (step_rem),
        .raddr (rd_addr_reg),
        .rdata (ram_rdata)
    );

    // Sequence each job: take from queue; answer invalid and zero jobs directly, divide and emit numbers
    always_comb
    begin
        state_next        = state_reg;
        div_next          = div_reg;
        part_next         = part_reg;
        step_next         = step_reg;
        idx_next          = idx_reg;
        rd_addr_next      = rd_addr_reg;
        rd_pending_next   = 1'b0;
        rd_last_next      = rd_last_reg;
        result_valid_next = 1'b0;
        digit_char_next   = digit_char_reg;
        last_digit_next   = last_digit_reg;
        base_invalid_next = base_invalid_reg;
        pop               = 1'b0;
        ram_we            = 1'b0;

        // Turn a returned digit into its symbol
        if (rd_pending_reg)
        begin
            result_valid_next = 1'b1;
            digit_char_next   = u2bd_pkg::symbol_at(symbols_low, symbols_high, ram_rdata);
            last_digit_next   = rd_last_reg;
            base_invalid_next = 1'b0;
        end

        unique case (state_reg)
            u2bd_pkg::BK_IDLE:
            begin
                if (job_valid && !rd_pending_reg)
                begin
                    pop = 1'b1;
                    unique case (job.kind)
                        u2bd_pkg::KIND_INVALID:
                        begin
                            result_valid_next = 1'b1;
                            digit_char_next   = '0;
                            last_digit_next   = 1'b1;
                            base_invalid_next = 1'b1;
                        end
                        u2bd_pkg::KIND_ZERO:
                        begin
                            result_valid_next = 1'b1;
                            digit_char_next   = u2bd_pkg::CHAR_ZERO;
                            last_digit_next   = 1'b1;
                            base_invalid_next = 1'b0;
                        end
                        u2bd_pkg::KIND_NUMBER:
                        begin
                            div_next   = DIV_W'(job.value[VALUE_BITS-1:0]);
                            part_next  = '0;
                            step_next  = '0;
                            idx_next   = '0;
                            state_next = u2bd_pkg::BK_DIVIDE;
                        end
                        default:
                        begin
                            state_next = u2bd_pkg::BK_IDLE;
                        end
                    endcase
                end
            end
            u2bd_pkg::BK_DIVIDE:
            begin
                div_next  = step_quo;
                part_next = step_rem;
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(STEPS - 1))
                begin
                    // Store the digit; stop at a zero quotient or a full store
                    ram_we    = 1'b1;
                    part_next = '0;
                    step_next = '0;
                    idx_next  = idx_reg + AW'(1);
                    if (step_quo == '0 || idx_reg == AW'(MAX_DIGITS - 1))
                    begin
                        rd_addr_next = idx_reg;
                        state_next   = u2bd_pkg::BK_EMIT;
                    end
                end
            end
            u2bd_pkg::BK_EMIT:
            begin
                rd_pending_next = 1'b1;
                rd_last_next    = (rd_addr_reg == '0);
                rd_addr_next    = rd_addr_reg - AW'(1);
                if (rd_addr_reg == '0)
                begin
                    state_next = u2bd_pkg::BK_IDLE;
                end
            end
            default:
            begin
                state_next = u2bd_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= u2bd_pkg::BK_IDLE;
            rd_pending_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            rd_pending_reg   <= rd_pending_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // Hold datapath and result payload
    always_ff @(posedge clk)
    begin
        div_reg          <= div_next;
        part_reg         <= part_next;
        step_reg         <= step_next;
        idx_reg          <= idx_next;
        rd_addr_reg      <= rd_addr_next;
        rd_last_reg      <= rd_last_next;
        digit_char_reg   <= digit_char_next;
        last_digit_reg   <= last_digit_next;
        base_invalid_reg <= base_invalid_next;
    end

    assign result_valid = result_valid_reg;
    assign digit_char   = digit_char_reg;
    assign last_digit   = last_digit_reg;
    assign base_invalid = base_invalid_reg;

`ifndef NO_ASSERTIONS
    // A job leaves the queue only when no digit read is in flight
    assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (state_reg == u2bd_pkg::BK_IDLE && !rd_pending_reg))
        else $error("job taken while a digit read is in flight");

    // Every emit cycle produces a result, through rd_pending_reg and then result_valid_reg
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == u2bd_pkg::BK_EMIT) |=> ##1 result_valid)
        else $error("digit read did not produce a result");

    // Partial remainder stays below the radix while dividing
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == u2bd_pkg::BK_DIVIDE) |-> ({1'b0, part_reg} < radix))
        else $error("partial remainder not below radix");

    // An error result is a single final result with a zero character
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && base_invalid) |-> (last_digit && digit_char == '0))
        else $error("malformed error result");
`endif

endmodule

// ===== hdl/uint_to_base_digits.sv =====
// Converts an unsigned value to digit symbols of a configured base, most
// significant digit first, one result per digit with last_digit on the
// final one. A value is taken when start is high and busy is low; busy
// rises only while the two-entry job queue is full. Each result is held
// for a single cycle under result_valid and cannot be stalled. An invalid
// symbol set yields one error result, and a zero value yields one '0'
// result, both registered when the back end takes the job from the queue.
// A nonzero value is divided by the radix once per digit: the radix divider
// retires eight dividend bits per cycle, and the digit store is then read
// back one digit per cycle, most significant digit first. Write
// configuration only while the block is idle.
module uint_to_base_digits #(
    parameter int MAX_SYMBOLS = u2bd_pkg::MAX_SYMBOLS_DEF,
    parameter int VALUE_BITS  = u2bd_pkg::VALUE_BITS_DEF,
    parameter int MAX_DIGITS  = u2bd_pkg::MAX_DIGITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [u2bd_pkg::VALUE_W-1:0]     value,
    input  logic                             cfg_write,
    input  logic [u2bd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [u2bd_pkg::CFG_DATA_W-1:0]  cfg_data,
    output logic                             result_valid,
    output logic [u2bd_pkg::CHAR_W-1:0]      digit_char,
    output logic                             last_digit,
    output logic                             base_invalid
);

    logic [u2bd_pkg::RADIX_W-1:0]    symbol_count_reg;
    logic [u2bd_pkg::CFG_DATA_W-1:0] symbols_low_reg;
    logic [u2bd_pkg::CFG_DATA_W-1:0] symbols_high_reg;

    logic           push;
    logic           pop;
    logic           queue_full;
    logic           job_valid;
    u2bd_pkg::job_t push_job;
    u2bd_pkg::job_t head_job;

    // Write configuration registers; drop writes past the last index
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            symbol_count_reg <= u2bd_pkg::RADIX_W'(u2bd_pkg::SYMBOL_COUNT_RESET);
            symbols_low_reg  <= '0;
            symbols_high_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                u2bd_pkg::CFG_SYMBOL_COUNT:
                begin
                    symbol_count_reg <= cfg_data[u2bd_pkg::RADIX_W-1:0];
                end
                u2bd_pkg::CFG_SYMBOLS_LOW:
                begin
                    symbols_low_reg <= cfg_data;
                end
                u2bd_pkg::CFG_SYMBOLS_HIGH:
                begin
                    symbols_high_reg <= cfg_data;
                end
                default:
                begin
                    symbol_count_reg <= symbol_count_reg;
                end
            endcase
        end
    end

    u2bd_front #(
        .MAX_SYMBOLS (MAX_SYMBOLS),
        .VALUE_BITS  (VALUE_BITS)
    ) u_front (
        .start        (start),
        .busy         (busy),
        .value        (value),
        .symbol_count (symbol_count_reg),
        .symbols_low  (symbols_low_reg),
        .symbols_high (symbols_high_reg),
        .queue_full   (queue_full),
        .push         (push),
        .job          (push_job)
    );

    u2bd_queue #(
        .DEPTH (u2bd_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_job  (push_job),
        .pop       (pop),
        .full      (queue_full),
        .not_empty (job_valid),
        .head      (head_job)
    );

    u2bd_back #(
        .VALUE_BITS (VALUE_BITS),
        .MAX_DIGITS (MAX_DIGITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .job_valid    (job_valid),
        .job          (head_job),
        .pop          (pop),
        .radix        (symbol_count_reg),
        .symbols_low  (symbols_low_reg),
        .symbols_high (symbols_high_reg),
        .result_valid (result_valid),
        .digit_char   (digit_char),
        .last_digit   (last_digit),
        .base_invalid (base_invalid)
    );

endmodule
